[rtl/rlb_pkg.sv]
// rgb layer blend: blend mode codes, pipeline depth and shared arithmetic helpers
package rlb_pkg;

    localparam int PIPE_DEPTH = 11;

    typedef enum logic [3:0] {
        MODE_REPLACE  = 4'd0,
        MODE_MAX      = 4'd1,
        MODE_MIN      = 4'd2,
        MODE_ADD      = 4'd3,
        MODE_SUB      = 4'd4,
        MODE_MULTIPLY = 4'd5,
        MODE_DIVIDE   = 4'd6,
        MODE_SCREEN   = 4'd7,
        MODE_OVERLAY  = 4'd8,
        MODE_DODGE    = 4'd9,
        MODE_BURN     = 4'd10,
        MODE_HARDLT   = 4'd11,
        MODE_SOFTLT   = 4'd12,
        MODE_GRAINEX  = 4'd13,
        MODE_GRAINMG  = 4'd14,
        MODE_DIFF     = 4'd15
    } t_mode;

    // floor(x / 255) by reciprocal estimate and remainder correction
    function automatic logic [17:0] div255(input logic [24:0] x);
        logic [25:0] s;
        logic [25:0] r;
        logic [17:0] q;
        s = {1'b0, x} + 26'(x >> 8) + 26'(x >> 16);
        q = s[25:8];
        r = {1'b0, x} - {q, 8'b0} + 26'(q);
        if (r >= 26'd765) begin
            q = q + 18'd3;
        end else if (r >= 26'd510) begin
            q = q + 18'd2;
        end else if (r >= 26'd255) begin
            q = q + 18'd1;
        end
        return q;
    endfunction

    function automatic logic [7:0] sat8(input logic [17:0] x);
        return (x > 18'd255) ? 8'd255 : x[7:0];
    endfunction

endpackage

[rtl/rlb_chan.sv]
// rgb layer blend: one color channel blend pipeline
module rlb_chan
    import rlb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  t_mode      i_mode,
    input  logic [7:0] i_base,
    input  logic [7:0] i_layer,
    output logic [7:0] o_out
);

    // stage 1
    logic [7:0]  r1_i, r1_m;
    t_mode       r1_mode;
    // stage 2
    logic [7:0]  r2_i, r2_m, r2_simple;
    t_mode       r2_mode;
    logic [15:0] r2_pim, r2_ps;
    logic [16:0] r2_po, r2_phl;
    logic        r2_hlhi;
    logic [7:0]  n2_simple;
    logic [15:0] n2_dn;
    logic [8:0]  n2_dd;
    logic [8:0]  n2_a;
    logic [7:0]  n2_b;
    logic [15:0] n2_po;
    // divider stages
    logic [15:0] r_dn [0:8];
    logic [8:0]  r_dd [0:8];
    logic [8:0]  r_dr [0:8];
    logic [7:0]  r_dq [0:8];
    logic        r_ds [0:8];
    // stage 3
    logic [7:0]  r3_i, r3_m, r3_res, r3_scr;
    logic [8:0]  r3_ovt;
    t_mode       r3_mode;
    logic [7:0]  n3_res, n3_scr;
    logic [7:0]  n3_hl;
    // stage 4
    logic [17:0] r4_op;
    logic [16:0] r4_t;
    logic [7:0]  r4_i, r4_res;
    t_mode       r4_mode;
    // stage 5
    logic [24:0] r5_t2;
    logic [7:0]  r5_res;
    t_mode       r5_mode;
    // stage 6
    logic [17:0] r6_s1;
    logic [7:0]  r6_res;
    t_mode       r6_mode;
    // stage 7 to 10
    logic [7:0]  r7_res;
    t_mode       r7_mode;
    logic [7:0]  r_dly_res [0:2];
    t_mode       r_dly_mode [0:2];
    // output
    logic [7:0]  r_out;
    logic [7:0]  n_out;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_i    <= i_base;
            r1_m    <= i_layer;
            r1_mode <= i_mode;
        end
    end

    // simple modes, products and divider setup
    always_comb begin
        case (r1_mode)
            MODE_REPLACE: n2_simple = r1_m;
            MODE_MAX:     n2_simple = (r1_i < r1_m) ? r1_m : r1_i;
            MODE_MIN:     n2_simple = (r1_i > r1_m) ? r1_m : r1_i;
            MODE_ADD:     n2_simple = sat8(18'(r1_i) + 18'(r1_m));
            MODE_SUB:     n2_simple = (r1_i > r1_m) ? (r1_i - r1_m) : 8'd0;
            MODE_GRAINEX: begin
                if ({1'b0, r1_i} + 9'd128 <= {1'b0, r1_m}) begin
                    n2_simple = 8'd0;
                end else begin
                    n2_simple = sat8(18'(r1_i) + 18'd128 - 18'(r1_m));
                end
            end
            MODE_GRAINMG: begin
                if ({1'b0, r1_i} + {1'b0, r1_m} <= 9'd128) begin
                    n2_simple = 8'd0;
                end else begin
                    n2_simple = sat8(18'(r1_i) + 18'(r1_m) - 18'd128);
                end
            end
            MODE_DIFF:    n2_simple = (r1_i > r1_m) ? (r1_i - r1_m) : (r1_m - r1_i);
            default:      n2_simple = r1_m;
        endcase
        case (r1_mode)
            MODE_DODGE: begin
                n2_dn = {r1_i, 8'd0};
                n2_dd = 9'd256 - {1'b0, r1_m};
            end
            MODE_BURN: begin
                n2_dn = {8'd255 - r1_i, 8'd0};
                n2_dd = {1'b0, r1_m} + 9'd1;
            end
            default: begin
                n2_dn = {r1_i, 8'd0};
                n2_dd = {1'b0, r1_m} + 9'd1;
            end
        endcase
        if (r1_m > 8'd128) begin
            n2_a = 9'd511 - {r1_m, 1'b0};
            n2_b = 8'd255 - r1_i;
        end else begin
            n2_a = {r1_m, 1'b0};
            n2_b = r1_i;
        end
        n2_po = (8'd255 - r1_i) * r1_m;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_i      <= r1_i;
            r2_m      <= r1_m;
            r2_mode   <= r1_mode;
            r2_simple <= n2_simple;
            r2_pim    <= r1_i * r1_m;
            r2_ps     <= (8'd255 - r1_i) * (8'd255 - r1_m);
            r2_po     <= {n2_po, 1'b0};
            r2_phl    <= n2_a * n2_b;
            r2_hlhi   <= r1_m > 8'd128;
            r_dn[0]   <= n2_dn;
            r_dd[0]   <= n2_dd;
            r_dr[0]   <= {1'b0, n2_dn[15:8]};
            r_dq[0]   <= 8'd0;
            r_ds[0]   <= {1'b0, n2_dn} >= {n2_dd, 8'd0};
        end
    end

    // one quotient bit per stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 8; k++) begin
                r_dn[k+1] <= r_dn[k];
                r_dd[k+1] <= r_dd[k];
                r_ds[k+1] <= r_ds[k];
                if ({r_dr[k], r_dn[k][7-k]} >= {1'b0, r_dd[k]}) begin
                    r_dr[k+1] <= 9'({r_dr[k], r_dn[k][7-k]} - {1'b0, r_dd[k]});
                    r_dq[k+1] <= {r_dq[k][6:0], 1'b1};
                end else begin
                    r_dr[k+1] <= 9'({r_dr[k], r_dn[k][7-k]});
                    r_dq[k+1] <= {r_dq[k][6:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        logic [17:0] q_s;
        q_s    = div255({9'd0, r2_ps});
        n3_scr = 8'd255 - q_s[7:0];
        n3_hl  = r2_hlhi ? (8'd255 - r2_phl[15:8]) : r2_phl[15:8];
        case (r2_mode)
            MODE_MULTIPLY: n3_res = sat8(div255({9'd0, r2_pim}));
            MODE_SCREEN:   n3_res = n3_scr;
            MODE_HARDLT:   n3_res = n3_hl;
            default:       n3_res = r2_simple;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            logic [17:0] q_o;
            q_o     = div255({8'd0, r2_po});
            r3_i    <= r2_i;
            r3_m    <= r2_m;
            r3_mode <= r2_mode;
            r3_res  <= n3_res;
            r3_scr  <= n3_scr;
            r3_ovt  <= q_o[8:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_op   <= {10'd0, r3_i} * ({8'd0, r3_i} + {7'd0, r3_ovt});
            r4_t    <= ({9'd0, 8'd255 - r3_i} * {9'd0, r3_m}) + ({9'd0, r3_scr} * 17'd255);
            r4_i    <= r3_i;
            r4_res  <= r3_res;
            r4_mode <= r3_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_t2   <= r4_t * r4_i;
            r5_res  <= (r4_mode == MODE_OVERLAY) ? sat8(div255({7'd0, r4_op})) : r4_res;
            r5_mode <= r4_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_s1   <= div255(r5_t2);
            r6_res  <= r5_res;
            r6_mode <= r5_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_res  <= (r6_mode == MODE_SOFTLT) ? sat8(div255({7'd0, r6_s1})) : r6_res;
            r7_mode <= r6_mode;
            r_dly_res[0]  <= r7_res;
            r_dly_mode[0] <= r7_mode;
            for (int k = 1; k < 3; k++) begin
                r_dly_res[k]  <= r_dly_res[k-1];
                r_dly_mode[k] <= r_dly_mode[k-1];
            end
        end
    end

    always_comb begin
        case (r_dly_mode[2])
            MODE_DIVIDE, MODE_DODGE: n_out = r_ds[8] ? 8'd255 : r_dq[8];
            MODE_BURN:               n_out = r_ds[8] ? 8'd0 : (8'd255 - r_dq[8]);
            default:                 n_out = r_dly_res[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

[rtl/rgb_layer_blend_unit.sv]
// rgb layer blend: top level with mode register, valid pipeline and three channels
//
//  channel | signals                                     | direction
//  in      | i_in_valid, o_in_stall, i_base_*, i_layer_* | request in
//  out     | o_out_valid, i_out_stall, o_out_*           | request out
//  cfg     | i_cfg_wr_en, i_cfg_wr_data                  | mode write
//
// one request per cycle unless a valid output is stalled
// pipeline depth set by the eight stage restoring divider for divide, dodge and burn
// synchronous active low reset clears the mode and all valid bits
// a stall while the output is valid freezes the whole pipe; otherwise every stage advances
module rgb_layer_blend_unit
    import rlb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [3:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_base_red,
    input  logic [7:0] i_base_green,
    input  logic [7:0] i_base_blue,
    input  logic [7:0] i_layer_red,
    input  logic [7:0] i_layer_green,
    input  logic [7:0] i_layer_blue,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue
);

    t_mode                 r_mode;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  en;

    assign en         = !(r_vld[PIPE_DEPTH-1] && i_out_stall);
    assign o_in_stall = !en;
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_REPLACE;
        end else if (i_cfg_wr_en) begin
            r_mode <= t_mode'(i_cfg_wr_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in_valid};
        end
    end

    rlb_chan u_red (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_mode  (r_mode),
        .i_base  (i_base_red),
        .i_layer (i_layer_red),
        .o_out   (o_out_red)
    );

    rlb_chan u_green (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_mode  (r_mode),
        .i_base  (i_base_green),
        .i_layer (i_layer_green),
        .o_out   (o_out_green)
    );

    rlb_chan u_blue (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_mode  (r_mode),
        .i_base  (i_base_blue),
        .i_layer (i_layer_blue),
        .o_out   (o_out_blue)
    );

endmodule

[rtl/rlb_checker.sv]
// rgb layer blend: port level checker and its bind to the top level
module rlb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_red,
    input logic [7:0] o_out_green,
    input logic [7:0] o_out_blue
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output request dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        ($stable(o_out_red) && $stable(o_out_green) && $stable(o_out_blue)))
        else $error("stalled output changed");

    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind rgb_layer_blend_unit rlb_checker u_rlb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_red   (o_out_red),
    .o_out_green (o_out_green),
    .o_out_blue  (o_out_blue)
);
